// ===== rtl/core/blest_pkg.sv =====
// ----------------------------------------------------------------------------
// Battery level estimator package
// Shared constants, control word and flag types and the microprogram ROM.
// ----------------------------------------------------------------------------
package blest_pkg;

    localparam int SAMPLE_W     = 12;
    localparam int NUM_SAMPLES  = 8;
    localparam int SAMPLE_IDX_W = $clog2(NUM_SAMPLES);
    localparam int SUM_W        = SAMPLE_W + SAMPLE_IDX_W;
    localparam int LEVEL_W      = 12;
    localparam int HIST_DEPTH   = 3;
    localparam int PCT_W        = 8;

    localparam int EMPTY_W      = 12;
    localparam int THRESH_W     = 7;
    localparam int DEBOUNCE_W   = 4;
    localparam int CFG_DATA_W   = 12;
    localparam int CFG_INDEX_W  = 2;

    localparam logic [EMPTY_W-1:0]    EMPTY_RESET    = 12'd2234;
    localparam logic [THRESH_W-1:0]   THRESH_RESET   = 7'd90;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 4'd10;

    localparam logic [CFG_INDEX_W-1:0] CFG_EMPTY_LEVEL    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FULL_THRESHOLD = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_LIMIT = 2'd2;

    // Working register and constant-divide datapath widths.
    localparam int NUM_W   = 21;
    localparam int RECIP_W = 15;
    localparam int PROD_W  = NUM_W + RECIP_W;
    localparam int QUOT_W  = 14;
    localparam int SPAN_W  = 11;

    // (avg - empty) * 100 / 350 is computed as ((avg - empty) * 2) / 7.
    localparam logic [RECIP_W-1:0] RECIP_7   = 15'd9362;
    localparam int                 SHIFT_7   = 16;
    localparam logic [RECIP_W-1:0] RECIP_100 = 15'd20971;
    localparam int                 SHIFT_100 = 21;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 12'd4095;
    localparam logic [PCT_W-1:0]   PCT_FULL    = 8'd100;
    localparam logic [PCT_W-1:0]   PCT_EMPTY   = 8'd1;
    localparam logic [PCT_W-1:0]   PCT_SAT     = 8'd255;

    localparam int STEP_W = 4;

    localparam logic [STEP_W-1:0] STEP_DEBOUNCE  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_ACCUM     = 4'd1;
    localparam logic [STEP_W-1:0] STEP_AVG       = 4'd2;
    localparam logic [STEP_W-1:0] STEP_MUL7      = 4'd3;
    localparam logic [STEP_W-1:0] STEP_FIX7      = 4'd4;
    localparam logic [STEP_W-1:0] STEP_SQUARE    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_MUL100    = 4'd6;
    localparam logic [STEP_W-1:0] STEP_FIX100    = 4'd7;
    localparam logic [STEP_W-1:0] STEP_PUSH      = 4'd8;
    localparam logic [STEP_W-1:0] STEP_OUT_LEVEL = 4'd9;
    localparam logic [STEP_W-1:0] STEP_OUT_HOLD  = 4'd10;
    localparam logic [STEP_W-1:0] STEP_OUT_LOW   = 4'd11;
    localparam logic [STEP_W-1:0] STEP_LAST      = STEP_OUT_LOW;

    typedef enum logic [3:0] {
        OP_DEBOUNCE,
        OP_ACCUM,
        OP_AVG,
        OP_MULREC,
        OP_DIVFIX,
        OP_SQUARE,
        OP_PUSH,
        OP_OUT_LEVEL,
        OP_OUT_HOLD,
        OP_OUT_LOW
    } blest_op_t;

    typedef enum logic {
        DIV_BY_7,
        DIV_BY_100
    } blest_div_t;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_HOLD,
        COND_LOOP,
        COND_LOW,
        COND_NO_CHG
    } blest_cond_t;

    typedef struct packed {
        blest_op_t          op;
        blest_div_t         div_sel;
        blest_cond_t        cond;
        logic [STEP_W-1:0]  target;
        logic               emit;
        logic               last;
    } blest_ctl_t;

    typedef struct packed {
        logic hold;
        logic loop_more;
        logic low;
        logic no_chg;
    } blest_flags_t;

    typedef struct packed {
        logic       en;
        blest_ctl_t ctl;
    } blest_seq_t;

    function automatic blest_ctl_t blest_rom(input logic [STEP_W-1:0] step);
        blest_ctl_t c;
        c = '{op: OP_OUT_LOW, div_sel: DIV_BY_7, cond: COND_NONE,
              target: STEP_DEBOUNCE, emit: 1'b0, last: 1'b0};
        case (step)
            STEP_DEBOUNCE:
            begin
                c.op     = OP_DEBOUNCE;
                c.cond   = COND_HOLD;
                c.target = STEP_OUT_HOLD;
            end
            STEP_ACCUM:
            begin
                c.op     = OP_ACCUM;
                c.cond   = COND_LOOP;
                c.target = STEP_ACCUM;
            end
            STEP_AVG:
            begin
                c.op     = OP_AVG;
                c.cond   = COND_LOW;
                c.target = STEP_OUT_LOW;
            end
            STEP_MUL7:
            begin
                c.op      = OP_MULREC;
                c.div_sel = DIV_BY_7;
            end
            STEP_FIX7:
            begin
                c.op      = OP_DIVFIX;
                c.div_sel = DIV_BY_7;
                c.cond    = COND_NO_CHG;
                c.target  = STEP_PUSH;
            end
            STEP_SQUARE:
            begin
                c.op = OP_SQUARE;
            end
            STEP_MUL100:
            begin
                c.op      = OP_MULREC;
                c.div_sel = DIV_BY_100;
            end
            STEP_FIX100:
            begin
                c.op      = OP_DIVFIX;
                c.div_sel = DIV_BY_100;
            end
            STEP_PUSH:
            begin
                c.op = OP_PUSH;
            end
            STEP_OUT_LEVEL:
            begin
                c.op   = OP_OUT_LEVEL;
                c.emit = 1'b1;
                c.last = 1'b1;
            end
            STEP_OUT_HOLD:
            begin
                c.op   = OP_OUT_HOLD;
                c.emit = 1'b1;
                c.last = 1'b1;
            end
            default:
            begin
                c.op   = OP_OUT_LOW;
                c.emit = 1'b1;
                c.last = 1'b1;
            end
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/blest_useq.sv =====
// ----------------------------------------------------------------------------
// Battery level estimator sequencer
// Step counter over the microprogram ROM with conditional jumps.
// ----------------------------------------------------------------------------
module blest_useq
    import blest_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         out_free,
    input  blest_flags_t flags,
    output logic         busy,
    output blest_seq_t   seq
);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    blest_ctl_t        ctl;
    logic              taken;

    always_comb
    begin
        ctl    = blest_rom(step_reg);
        seq.ctl = ctl;
        seq.en  = busy_reg && (!ctl.emit || out_free);

        case (ctl.cond)
            COND_HOLD:   taken = flags.hold;
            COND_LOOP:   taken = flags.loop_more;
            COND_LOW:    taken = flags.low;
            COND_NO_CHG: taken = flags.no_chg;
            default:     taken = 1'b0;
        endcase

        busy_next = busy_reg;
        step_next = step_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_DEBOUNCE;
        end
        else if (seq.en)
        begin
            if (ctl.last)
            begin
                busy_next = 1'b0;
            end
            else if (taken)
            begin
                step_next = ctl.target;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= STEP_DEBOUNCE;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    assign busy = busy_reg;

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (step_reg <= STEP_LAST))
        else $error("sequencer step outside the microprogram");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("new request started while a request is in progress");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (seq.en && ctl.last) |=> !busy_reg)
        else $error("sequencer still busy after its final step");

endmodule

// ===== rtl/core/blest_dpath.sv =====
// ----------------------------------------------------------------------------
// Battery level estimator datapath
// Sample store, debounce state, level history and the shared arithmetic.
// ----------------------------------------------------------------------------
module blest_dpath
    import blest_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [NUM_SAMPLES*SAMPLE_W-1:0] samples,
    input  logic                       charging,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  blest_seq_t                 seq,
    output blest_flags_t               flags,
    output logic [PCT_W-1:0]           result
);

    logic [SAMPLE_W-1:0]     sample_reg [NUM_SAMPLES];
    logic                    chg_reg;
    logic [SAMPLE_IDX_W-1:0] idx_reg, idx_next;
    logic [NUM_W-1:0]        num_reg, num_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [LEVEL_W-1:0]      hist_reg [HIST_DEPTH];
    logic [LEVEL_W-1:0]      hist_next [HIST_DEPTH];
    logic                    acc_chg_reg, acc_chg_next;
    logic [DEBOUNCE_W-1:0]   cnt_reg, cnt_next;
    logic [EMPTY_W-1:0]      empty_reg;
    logic [THRESH_W-1:0]     thresh_reg;
    logic [DEBOUNCE_W-1:0]   limit_reg;

    logic [LEVEL_W-1:0]      oldest;
    logic [DEBOUNCE_W-1:0]   cnt_inc;
    logic                    changed;
    logic                    change_done;
    logic [SAMPLE_W-1:0]     avg;
    logic [SAMPLE_W:0]       span;
    logic [RECIP_W-1:0]      recip;
    logic [QUOT_W-1:0]       quot0;
    logic [NUM_W:0]          remainder;
    logic [NUM_W:0]          qd;
    logic [7:0]              divisor;
    logic [QUOT_W-1:0]       quot;
    logic [2*SPAN_W-1:0]     square;

    assign oldest      = hist_reg[HIST_DEPTH-1];
    assign changed     = chg_reg != acc_chg_reg;
    assign cnt_inc     = cnt_reg + 1'b1;
    assign change_done = cnt_inc >= limit_reg;
    assign avg         = num_reg[SUM_W-1:SAMPLE_IDX_W];
    assign span        = {1'b0, avg} - {1'b0, empty_reg};

    always_comb
    begin
        flags.hold      = changed && !change_done && (oldest != '0);
        flags.loop_more = idx_reg != SAMPLE_IDX_W'(NUM_SAMPLES - 1);
        flags.low       = avg <= empty_reg;
        flags.no_chg    = !chg_reg;
    end

    // Divide by a constant: floor reciprocal multiply, then one correction.
    always_comb
    begin
        if (seq.ctl.div_sel == DIV_BY_7)
        begin
            recip   = RECIP_7;
            quot0   = QUOT_W'(prod_reg >> SHIFT_7);
            divisor = 8'd7;
        end
        else
        begin
            recip   = RECIP_100;
            quot0   = QUOT_W'(prod_reg >> SHIFT_100);
            divisor = 8'd100;
        end
        qd        = (NUM_W+1)'(quot0) * (NUM_W+1)'(divisor);
        remainder = {1'b0, num_reg} - qd;
        quot      = quot0 + QUOT_W'(remainder >= (NUM_W+1)'(divisor));
        square    = {SPAN_W'(0), num_reg[SPAN_W-1:0]} * {SPAN_W'(0), num_reg[SPAN_W-1:0]};
    end

    always_comb
    begin
        idx_next     = idx_reg;
        num_next     = num_reg;
        prod_next    = prod_reg;
        acc_chg_next = acc_chg_reg;
        cnt_next     = cnt_reg;
        result       = PCT_EMPTY;
        for (int i = 0; i < HIST_DEPTH; i++)
        begin
            hist_next[i] = hist_reg[i];
        end

        case (seq.ctl.op)
            OP_DEBOUNCE:
            begin
                idx_next = '0;
                num_next = '0;
                if (changed)
                begin
                    if (change_done)
                    begin
                        cnt_next     = '0;
                        acc_chg_next = chg_reg;
                    end
                    else
                    begin
                        cnt_next = cnt_inc;
                    end
                end
                else
                begin
                    cnt_next = '0;
                end
            end
            OP_ACCUM:
            begin
                num_next = num_reg + NUM_W'(sample_reg[idx_reg]);
                idx_next = idx_reg + 1'b1;
            end
            OP_AVG:
            begin
                num_next = NUM_W'({span[SAMPLE_W-1:0], 1'b0});
            end
            OP_MULREC:
            begin
                prod_next = PROD_W'(num_reg) * PROD_W'(recip);
            end
            OP_DIVFIX:
            begin
                // After the divide by 7 the scaled level is lifted to at least one percent.
                if (seq.ctl.div_sel == DIV_BY_7 && quot == '0)
                begin
                    num_next = NUM_W'(1);
                end
                else
                begin
                    num_next = NUM_W'(quot);
                end
            end
            OP_SQUARE:
            begin
                num_next = square[NUM_W-1:0];
            end
            OP_PUSH:
            begin
                for (int i = HIST_DEPTH - 1; i > 0; i--)
                begin
                    hist_next[i] = hist_reg[i-1];
                end
                hist_next[0] = (num_reg > NUM_W'(LEVEL_MAX)) ? LEVEL_MAX
                                                             : num_reg[LEVEL_W-1:0];
            end
            OP_OUT_LEVEL:
            begin
                result = (oldest > LEVEL_W'(thresh_reg)) ? PCT_FULL : oldest[PCT_W-1:0];
            end
            OP_OUT_HOLD:
            begin
                for (int i = 0; i < HIST_DEPTH; i++)
                begin
                    hist_next[i] = oldest;
                end
                result = (oldest > LEVEL_W'(PCT_SAT)) ? PCT_SAT : oldest[PCT_W-1:0];
            end
            OP_OUT_LOW:
            begin
                result = PCT_EMPTY;
            end
            default:
            begin
                result = PCT_EMPTY;
            end
        endcase
    end

    // Request payload and scratch registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int i = 0; i < NUM_SAMPLES; i++)
            begin
                sample_reg[i] <= samples[i*SAMPLE_W +: SAMPLE_W];
            end
            chg_reg <= charging;
        end
        if (seq.en)
        begin
            idx_reg  <= idx_next;
            num_reg  <= num_next;
            prod_reg <= prod_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_chg_reg <= 1'b0;
            cnt_reg     <= '0;
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
            empty_reg  <= EMPTY_RESET;
            thresh_reg <= THRESH_RESET;
            limit_reg  <= DEBOUNCE_RESET;
        end
        else
        begin
            if (seq.en)
            begin
                acc_chg_reg <= acc_chg_next;
                cnt_reg     <= cnt_next;
                for (int i = 0; i < HIST_DEPTH; i++)
                begin
                    hist_reg[i] <= hist_next[i];
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_EMPTY_LEVEL:    empty_reg  <= cfg_data[EMPTY_W-1:0];
                    CFG_FULL_THRESHOLD: thresh_reg <= cfg_data[THRESH_W-1:0];
                    CFG_DEBOUNCE_LIMIT: limit_reg  <= cfg_data[DEBOUNCE_W-1:0];
                    default:            ;
                endcase
            end
        end
    end

endmodule

// ===== rtl/core/battery_level_estimator.sv =====
// ----------------------------------------------------------------------------
// Battery level estimator
// Eight voltage samples and a charger flag in, one battery percentage out.
// ----------------------------------------------------------------------------
// Steps: debounce, then the eight-pass sample accumulation loop and the
// average; on the discharging path multiply and fix for the divide by 7,
// push and output, while charging also square and divide by 100 before the
// push. An average at or below the empty level goes straight to the empty
// output, and a pending charger change holds the last level. The output step
// waits while the output register is still full.
// One request at a time: the next is taken only after the result is loaded.
// Reset: asynchronous, active low; history, debounce state and registers
// return to their reset values at once, with no clearing pass.
// ----------------------------------------------------------------------------
module battery_level_estimator
    import blest_pkg::*;
(
    input  logic                             clk,
    input  logic                             rst_n,
    // sample_0 .. sample_7, 12 bits each, sample_0 in the lowest bits
    input  logic [NUM_SAMPLES*SAMPLE_W-1:0]  s_tdata,
    // charging
    input  logic                             s_tuser,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // percent
    output logic [PCT_W-1:0]                 m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_we,
    input  logic [CFG_INDEX_W-1:0]           cfg_index,
    input  logic [CFG_DATA_W-1:0]            cfg_data
);

    // A request is taken whenever the sequencer is idle, even if the previous
    // result still sits in the output register. The final step of the
    // microprogram, which writes that register, waits until it is free.
    logic                 busy;
    logic                 start;
    logic                 out_free;
    blest_seq_t           seq;
    blest_flags_t         flags;
    logic [PCT_W-1:0]     result;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [PCT_W-1:0]     m_tdata_reg, m_tdata_next;

    assign s_tready = !busy;
    assign start    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    blest_useq u_useq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .out_free (out_free),
        .flags    (flags),
        .busy     (busy),
        .seq      (seq)
    );

    blest_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .samples   (s_tdata),
        .charging  (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .seq       (seq),
        .flags     (flags),
        .result    (result)
    );

    // Output register: loaded by an emitting step, cleared once taken.
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (seq.en && seq.ctl.emit)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== sim/battery_level_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Battery level checker
// Watches the request, result and register ports of the estimator, predicts
// each battery percentage and compares it with the result that comes out.
// ----------------------------------------------------------------------------
module battery_level_checker
    import blest_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    // sample_0 .. sample_7, 12 bits each, sample_0 in the lowest bits
    input  logic [NUM_SAMPLES*SAMPLE_W-1:0] s_tdata,
    // charging
    input  logic                            s_tuser,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // percent
    input  logic [PCT_W-1:0]                m_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_we,
    input  logic [CFG_INDEX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]           cfg_data,
    output int                              pending,
    output int                              fail_count
);

    localparam int unsigned SPAN_DIV    = 350;
    localparam int unsigned PCT_SCALE   = 100;
    localparam int          MAX_REPORTS = 10;

    logic [EMPTY_W-1:0]    empty_level;
    logic [THRESH_W-1:0]   full_threshold;
    logic [DEBOUNCE_W-1:0] debounce_limit;

    logic                  acc_charging;
    logic [DEBOUNCE_W-1:0] change_cnt;
    logic [LEVEL_W-1:0]    level_hist [HIST_DEPTH];

    logic [PCT_W-1:0]      expected_percent [$];
    logic [PCT_W-1:0]      want;

    // Updates the debounce state and the history for one request and
    // returns the percentage that the request must produce.
    function automatic logic [PCT_W-1:0] predict_percent(
        input logic [NUM_SAMPLES*SAMPLE_W-1:0] samples,
        input logic                            charging
    );
        int unsigned        total;
        int unsigned        avg;
        int unsigned        pct;
        logic [LEVEL_W-1:0] oldest;
        total = 0;
        oldest = level_hist[HIST_DEPTH-1];
        if (charging != acc_charging)
        begin
            change_cnt = change_cnt + 1'b1;
            if (change_cnt >= debounce_limit)
            begin
                change_cnt = '0;
                acc_charging = charging;
            end
            else if (oldest != '0)
            begin
                // A pending charger change holds the oldest level everywhere.
                for (int i = 0; i < HIST_DEPTH; i++)
                    level_hist[i] = oldest;
                return (oldest > PCT_SAT) ? PCT_SAT : oldest[PCT_W-1:0];
            end
        end
        else
        begin
            change_cnt = '0;
        end

        for (int i = 0; i < NUM_SAMPLES; i++)
            total += samples[i*SAMPLE_W +: SAMPLE_W];
        avg = total / NUM_SAMPLES;
        if (avg <= empty_level)
            return PCT_EMPTY;

        pct = (avg - empty_level) * PCT_SCALE / SPAN_DIV;
        if (pct == 0)
            pct = 1;
        if (charging)
            pct = pct * pct / PCT_SCALE;
        if (pct > LEVEL_MAX)
            pct = LEVEL_MAX;

        for (int i = HIST_DEPTH - 1; i > 0; i--)
            level_hist[i] = level_hist[i-1];
        level_hist[0] = pct[LEVEL_W-1:0];
        oldest = level_hist[HIST_DEPTH-1];
        return (oldest > full_threshold) ? PCT_FULL : oldest[PCT_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_level    = EMPTY_RESET;
            full_threshold = THRESH_RESET;
            debounce_limit = DEBOUNCE_RESET;
            acc_charging   = 1'b0;
            change_cnt     = '0;
            for (int i = 0; i < HIST_DEPTH; i++)
                level_hist[i] = '0;
            expected_percent.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_EMPTY_LEVEL:    empty_level    = cfg_data[EMPTY_W-1:0];
                    CFG_FULL_THRESHOLD: full_threshold = cfg_data[THRESH_W-1:0];
                    CFG_DEBOUNCE_LIMIT: debounce_limit = cfg_data[DEBOUNCE_W-1:0];
                    default:            ;
                endcase
            end

            if (s_tvalid && s_tready)
                expected_percent.push_back(predict_percent(s_tdata, s_tuser));

            if (m_tvalid && m_tready)
            begin
                if (expected_percent.size() == 0)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("unexpected result: percent %0d", m_tdata);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = expected_percent.pop_front();
                    if (m_tdata !== want)
                    begin
                        if (fail_count < MAX_REPORTS)
                            $display("percent mismatch: expected %0d, actual %0d",
                                     want, m_tdata);
                        fail_count = fail_count + 1;
                    end
                end
            end

            pending <= expected_percent.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Battery level estimator testbench
// Drives requests of eight voltage samples and a charger flag with random
// gaps and result back-pressure, across several register settings, while a
// checker predicts every percentage and compares it with the block's output.
// ----------------------------------------------------------------------------
module testbench;
    import blest_pkg::*;

    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int MAX_IDLE        = 5;
    localparam int RESET_CYCLES    = 12;
    localparam int DRAIN_CYCLES    = 30;
    localparam int SETTLE_CYCLES   = 4;
    localparam int LONGEST_RUN     = 18;

    // Index past the three registers; a write there must change nothing.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic [NUM_SAMPLES*SAMPLE_W-1:0] s_tdata;
    logic                            s_tuser;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [PCT_W-1:0]                m_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic                            cfg_we;
    logic [CFG_INDEX_W-1:0]          cfg_index;
    logic [CFG_DATA_W-1:0]           cfg_data;

    int pending_results;
    int fail_count;

    // Idling switches, changed per phase so that some stretches run flat out.
    bit sender_idles;
    bit receiver_idles;

    // Stimulus shaping: the current empty level lets most requests aim their
    // average just around the interesting span, and the charger flag moves in
    // runs so that debounce windows are both crossed and cut short.
    int   empty_now;
    logic charging_now;
    int   run_left;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    battery_level_estimator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    battery_level_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pending    (pending_results),
        .fail_count (fail_count)
    );

    // Eight samples scattered around a center value, clipped to the ADC range.
    // A spread of zero gives a uniform request.
    function automatic logic [NUM_SAMPLES*SAMPLE_W-1:0] spread_samples(
        input int center,
        input int spread
    );
        logic [NUM_SAMPLES*SAMPLE_W-1:0] word;
        int                              v;
        for (int i = 0; i < NUM_SAMPLES; i++)
        begin
            v = int'($urandom_range(0, 2 * spread));
            v = center + v - spread;
            if (v < 0)
                v = 0;
            if (v > SAMPLE_MAX)
                v = SAMPLE_MAX;
            word[i*SAMPLE_W +: SAMPLE_W] = v[SAMPLE_W-1:0];
        end
        return word;
    endfunction

    // Presents one request, optionally after an idle gap, and returns at the
    // edge where it is accepted. The valid stays high afterwards so that a
    // back-to-back request needs no second assignment in the same step.
    task automatic send_request(
        input logic [NUM_SAMPLES*SAMPLE_W-1:0] samples,
        input logic                            charging
    );
        int gap;
        gap = sender_idles ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= samples;
        s_tuser  <= charging;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Stops sending and waits until every predicted result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
    endtask

    task automatic write_reg(
        input logic [CFG_INDEX_W-1:0] index,
        input logic [CFG_DATA_W-1:0]  value
    );
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Registers change only with the block idle; the write enable stays high
    // across the whole burst and drops once at the end.
    task automatic apply_settings(
        input logic [CFG_DATA_W-1:0] empty,
        input logic [CFG_DATA_W-1:0] threshold,
        input logic [CFG_DATA_W-1:0] debounce,
        input bit                    poke_unused
    );
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_EMPTY_LEVEL, empty);
        write_reg(CFG_FULL_THRESHOLD, threshold);
        write_reg(CFG_DEBOUNCE_LIMIT, debounce);
        if (poke_unused)
            write_reg(CFG_UNUSED_INDEX, CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
        empty_now = empty;
    endtask

    // One random request. Most aim their average from just below the empty
    // level up to well past full; the rest are wide noise or rail values.
    task automatic send_random_request();
        int kind;
        int offset;
        if (run_left == 0)
        begin
            charging_now = ~charging_now;
            run_left = $urandom_range(1, LONGEST_RUN);
        end
        run_left--;
        kind = $urandom_range(0, 9);
        if (kind == 0)
            send_request(spread_samples(2048, 2048), charging_now);
        else if (kind == 1)
            send_request(spread_samples($urandom_range(0, 1) * SAMPLE_MAX, 0),
                         charging_now);
        else
        begin
            offset = int'($urandom_range(0, 1300)) - 100;
            send_request(spread_samples(empty_now + offset, $urandom_range(0, 40)),
                         charging_now);
        end
    endtask

    // Random register settings, with the extremes forced in the first phases
    // and drawn now and then later. Raw 12-bit data checks the width masking.
    task automatic pick_settings(input int phase);
        logic [CFG_DATA_W-1:0] empty;
        logic [CFG_DATA_W-1:0] threshold;
        logic [CFG_DATA_W-1:0] debounce;
        case (phase)
            0: begin empty = 0;     threshold = 0;   debounce = 1;  end
            1: begin empty = 4095;  threshold = 100; debounce = 15; end
            2: begin empty = 2234;  threshold = 12'hFFF; debounce = 0; end
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       empty = 0;
                    1:       empty = CFG_DATA_W'($urandom_range(0, 4095));
                    default: empty = CFG_DATA_W'($urandom_range(1500, 3000));
                endcase
                threshold = ($urandom_range(0, 3) == 0)
                            ? CFG_DATA_W'($urandom_range(0, 4095))
                            : CFG_DATA_W'($urandom_range(0, 100));
                debounce  = ($urandom_range(0, 3) == 0)
                            ? CFG_DATA_W'($urandom_range(0, 4095))
                            : CFG_DATA_W'($urandom_range(1, 15));
            end
        endcase
        apply_settings(empty, threshold, debounce, (phase % 3) == 0);
    endtask

    // Result side: every result waits a random number of cycles with ready
    // low, unless back-pressure is switched off for the phase.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            stall = receiver_idles ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // Generous bound on the whole run: a timeout that reports failure.
    initial
    begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        logic [NUM_SAMPLES*SAMPLE_W-1:0] checkerboard;
        int                              pause_at;

        rst_n          = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        s_tvalid       = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_EMPTY_LEVEL;
        cfg_data       = '0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        empty_now      = EMPTY_RESET;
        charging_now   = 1'b0;
        run_left       = 0;
        for (int i = 0; i < NUM_SAMPLES; i++)
            checkerboard[i*SAMPLE_W +: SAMPLE_W] = (i % 2) ? 12'h555 : 12'hAAA;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset settings. Rails and an alternating bit
        // pattern first, then averages right at, just above and a little
        // above the empty level, the one just above rounding to zero percent
        // and being lifted to one.
        send_request(spread_samples(0, 0), 1'b0);
        send_request(spread_samples(SAMPLE_MAX, 0), 1'b0);
        send_request(checkerboard, 1'b0);
        send_request(spread_samples(EMPTY_RESET, 0), 1'b0);
        send_request(spread_samples(EMPTY_RESET + 1, 0), 1'b0);
        send_request(spread_samples(EMPTY_RESET + 4, 0), 1'b0);
        send_request(spread_samples(SAMPLE_MAX, 0), 1'b0);
        // A one-request charger glitch holds the level, and the return to
        // the old status clears the debounce count.
        send_request(spread_samples(SAMPLE_MAX, 0), 1'b1);
        send_request(spread_samples(SAMPLE_MAX, 0), 1'b0);
        // A lasting change: held until the debounce limit, then accepted and
        // squared as a charging level.
        repeat (DEBOUNCE_RESET) send_request(spread_samples(3000, 0), 1'b1);

        // Empty level zero lets charging squares overflow the history width;
        // a debounce limit of zero accepts every change at once, and the
        // threshold write of all ones lands masked at its top value.
        apply_settings(0, 12'hFFF, 0, 1'b1);
        repeat (3) send_request(spread_samples(SAMPLE_MAX, 0), 1'b1);
        // With a long debounce the saturated history is held and clipped.
        apply_settings(0, 12'hFFF, 15, 1'b0);
        send_request(spread_samples(SAMPLE_MAX, 0), 1'b0);
        charging_now = 1'b1;

        // Random part, one register setting per phase.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            pick_settings(phase);
            sender_idles   = (phase % 4 != 1) && ($urandom_range(0, 3) != 0);
            receiver_idles = (phase % 4 != 2) && ($urandom_range(0, 3) != 0);
            pause_at = $urandom_range(0, ITEMS_PER_PHASE - 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Once per phase the sender holds off until all is answered.
                if (n == pause_at)
                    wait_drained();
                send_random_request();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
